// ----- design/lz77_flag_byte_decoder_assert.svh -----
// Assertion macros for the LZ77 flag-byte decoder.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef LZ77_FLAG_BYTE_DECODER_ASSERT_SVH
`define LZ77_FLAG_BYTE_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LZFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lzfd_pkg.sv -----
// Shared types and constants of the LZ77 flag-byte decoder.
// No dependencies; used by the controller, the datapath and the top level.
package lzfd_pkg;

    localparam int HIST_AW    = 12;
    localparam int HIST_DEPTH = 4096;
    localparam int NIBBLE_MAX = 15;

    localparam logic [3:0]       FLAG_COUNT = 4'd8;
    localparam logic [HIST_AW:0] COUNT_MAX  = 13'd4096;

    typedef enum logic [1:0] {
        KIND_FLAG,
        KIND_TOKEN,
        KIND_LITERAL,
        KIND_MATCH
    } tok_kind_t;

    typedef struct packed {
        logic load;
        logic parse;
        logic start_match;
        logic read;
        logic emit_lit;
        logic emit_match;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        tok_kind_t kind;
        logic      out_free;
        logic      match_done;
    } dp_status_t;

endpackage

// ----- design/lzfd_ctrl.sv -----
// Sequencing state machine of the LZ77 flag-byte decoder.
// Depends on lzfd_pkg; drives datapath commands from datapath status.
module lzfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lzfd_pkg::dp_status_t status,
    output lzfd_pkg::dp_cmd_t    cmd
);
    import lzfd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (status.kind) inside
                    KIND_FLAG, KIND_TOKEN:
                    begin
                        cmd.parse  = 1'b1;
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    KIND_LITERAL:
                    begin
                        if (status.out_free)
                        begin
                            cmd.parse    = 1'b1;
                            cmd.emit_lit = 1'b1;
                            cmd.finish   = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    KIND_MATCH:
                    begin
                        cmd.parse       = 1'b1;
                        cmd.start_match = 1'b1;
                        cmd.read        = 1'b1;
                        state_next      = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_match = 1'b1;
                    if (status.match_done)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/lzfd_datapath.sv -----
// Datapath of the LZ77 flag-byte decoder: parser state, history memory,
// match counters and output register. Depends on lzfd_pkg.
module lzfd_datapath #(
    parameter int MIN_MATCH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  lzfd_pkg::dp_cmd_t    cmd,
    output lzfd_pkg::dp_status_t status,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 run_last,
    output logic                 bad_distance,
    output logic                 out_valid
);
    import lzfd_pkg::*;

    localparam int LEN_W = $clog2(NIBBLE_MAX + MIN_MATCH + 1);

    logic [7:0]         hist_mem [HIST_DEPTH];
    logic [7:0]         rd_data_reg;

    logic [7:0]         byte_reg;
    logic               last_reg;

    logic [7:0]         flag_bits_reg, flag_bits_next;
    logic [3:0]         flags_left_reg, flags_left_next;
    logic               phase_reg, phase_next;
    logic [7:0]         held_reg, held_next;
    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic [HIST_AW:0]   count_reg, count_next;
    logic [HIST_AW:0]   dist_reg, dist_next;
    logic [LEN_W-1:0]   len_left_reg, len_left_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    logic               run_last_reg;
    logic               bad_reg;

    tok_kind_t          kind;
    logic               flag_bit;
    logic [HIST_AW:0]   dist_new;
    logic [LEN_W-1:0]   len_new;
    logic               bad_now;
    logic               wr_en;
    logic [7:0]         wr_data;
    logic [HIST_AW-1:0] rd_addr;
    logic               out_free;

    always_comb
    begin
        flag_bit = flag_bits_reg[3'(flags_left_reg - 4'd1)];
        if (phase_reg)
        begin
            kind = KIND_MATCH;
        end
        else if (flags_left_reg == 4'd0)
        begin
            kind = KIND_FLAG;
        end
        else if (flag_bit)
        begin
            kind = KIND_TOKEN;
        end
        else
        begin
            kind = KIND_LITERAL;
        end
    end

    assign dist_new = {1'b0, held_reg[3:0], byte_reg} + 13'd1;
    assign len_new  = LEN_W'(held_reg[7:4]) + LEN_W'(MIN_MATCH);
    assign bad_now  = (dist_reg > count_reg);
    assign wr_en    = cmd.emit_lit || cmd.emit_match;
    assign wr_data  = cmd.emit_lit ? byte_reg : (bad_now ? 8'd0 : rd_data_reg);
    assign rd_addr  = wp_reg - (cmd.start_match ? dist_new[HIST_AW-1:0]
                                                : dist_reg[HIST_AW-1:0]);
    assign out_free = !out_valid_reg || !out_stall;

    assign status.kind       = kind;
    assign status.out_free   = out_free;
    assign status.match_done = (len_left_reg == LEN_W'(1));

    always_comb
    begin
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        phase_next      = phase_reg;
        held_next       = held_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        dist_next       = dist_reg;
        len_left_next   = len_left_reg;

        if (cmd.parse)
        begin
            unique case (kind)
                KIND_FLAG:
                begin
                    flag_bits_next  = byte_reg;
                    flags_left_next = FLAG_COUNT;
                end
                KIND_TOKEN:
                begin
                    held_next       = byte_reg;
                    phase_next      = 1'b1;
                    flags_left_next = flags_left_reg - 4'd1;
                end
                KIND_LITERAL:
                begin
                    flags_left_next = flags_left_reg - 4'd1;
                end
                KIND_MATCH:
                begin
                    phase_next = 1'b0;
                    held_next  = 8'd0;
                end
                default:
                begin
                    phase_next = 1'b0;
                end
            endcase
        end

        if (cmd.start_match)
        begin
            dist_next     = dist_new;
            len_left_next = len_new;
        end
        if (cmd.emit_match)
        begin
            len_left_next = len_left_reg - LEN_W'(1);
        end

        if (wr_en)
        begin
            wp_next = wp_reg + 1'b1;
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        // End of stream: drop any half token and restart the window.
        if (cmd.finish && last_reg)
        begin
            flag_bits_next  = 8'd0;
            flags_left_next = 4'd0;
            phase_next      = 1'b0;
            held_next       = 8'd0;
            wp_next         = '0;
            count_next      = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (wr_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_bits_reg  <= 8'd0;
            flags_left_reg <= 4'd0;
            phase_reg      <= 1'b0;
            held_reg       <= 8'd0;
            wp_reg         <= '0;
            count_reg      <= '0;
            len_left_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            wp_reg         <= wp_next;
            count_reg      <= count_next;
            len_left_reg   <= len_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        if (cmd.load)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (wr_en)
        begin
            out_byte_reg <= wr_data;
            run_last_reg <= cmd.emit_lit ? 1'b1 : status.match_done;
            bad_reg      <= cmd.emit_match && bad_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wp_reg] <= wr_data;
        end
        if (cmd.read)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign run_last     = run_last_reg;
    assign bad_distance = bad_reg;

endmodule

// ----- design/lz77_flag_byte_decoder.sv -----
// Top level of the LZ77 flag-byte decoder (4096-byte window LZSS).
// Depends on lzfd_pkg, lzfd_ctrl, lzfd_datapath and the assertion header.
// Input channel (in_valid / in_stall, in_byte, in_last): one compressed
//   byte per item. A flag byte opens each group of eight tokens, MSB first;
//   a clear bit is a literal byte, a set bit a two-byte match token.
// Output channel (out_valid / out_stall, out_byte, run_last, bad_distance):
//   one decompressed byte per item; run_last marks the last byte caused by
//   an input item, bad_distance a match byte that reached before the
//   stream start (out_byte is then zero).
// Timing: an input item is taken only while the controller is idle. A flag
//   byte or first token byte is parsed in the decode state; a literal is
//   written there too, once the output is free. A match token's second byte
//   then alternates read and emit states, once per match byte. Each match
//   byte needs one read of the single history memory and then one write.
// Output path: a literal is written to the output register from the decode
//   state, a match byte from the emit state after its history read.
// Stall: a stalled output holds its item; a literal or match byte that is
//   due then waits, with in_stall high, until the output register frees up.
// Reset: the parser expects a flag byte and the window is empty; history is
//   not cleared. in_last restarts the parser after its item.
module lz77_flag_byte_decoder #(
    parameter int MIN_MATCH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       bad_distance
);
    import lzfd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       dp_write;

    // Sequence each item: decode, then read/emit once per match byte.
    lzfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold parser state, history window and the output register.
    lzfd_datapath #(
        .MIN_MATCH (MIN_MATCH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .bad_distance (bad_distance),
        .out_valid    (out_valid)
    );

    // Any history write also loads the output register.
    assign dp_write = cmd.emit_lit || cmd.emit_match;

`include "lz77_flag_byte_decoder_assert.svh"

    `LZFD_ASSERT_NOW(a_emit_free, dp_write, status.out_free, "write over a full output")
    `LZFD_ASSERT_NOW(a_read_no_write, cmd.read, !dp_write, "history read and write together")
    `LZFD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept while busy")
    `LZFD_ASSERT_NOW(a_bad_zero, out_valid && bad_distance, out_byte == 8'd0, "bad byte nonzero")

endmodule
